// File: design/bpc_pkg.sv
// Shared types and constants for the button press classifier.
package bpc_pkg;

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_SHORT    = 2'd1,
        EV_SHUTDOWN = 2'd2
    } bpc_event_t;

    // Register indexes on the configuration port (paddr[3:2])
    typedef enum logic [1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_HOLD      = 2'd1,
        REG_SHORT_MIN = 2'd2,
        REG_SHORT_MAX = 2'd3
    } bpc_reg_t;

    localparam int LIMIT_BITS = 16;

    localparam logic [LIMIT_BITS-1:0] DEBOUNCE_RESET  = 16'd20;
    localparam logic [LIMIT_BITS-1:0] HOLD_RESET      = 16'd3000;
    localparam logic [LIMIT_BITS-1:0] SHORT_MIN_RESET = 16'd50;
    localparam logic [LIMIT_BITS-1:0] SHORT_MAX_RESET = 16'd1000;

    // Result payload as packed into m_tdata, highest bits first
    typedef struct packed {
        logic [3:0] pad;
        logic       pressed;
        logic       hold_reached;
        bpc_event_t event_res;
    } bpc_result_t;

endpackage

// File: design/button_press_classifier.sv
// Top level of the button press classifier: debounce, hold and short-press detection.
//
// One input request per tick carries the raw active-low pin level in s_tdata[0].
// Each accepted request yields exactly one result on the master side:
//   m_tdata[1:0] event_res (0 none, 1 short press, 2 shutdown on release),
//   m_tdata[2] hold_reached, m_tdata[3] debounced pressed state.
// The state update is a single pass of counters and compares from the accepted
// request into the state registers and the result register, so a result appears
// in the cycle after its request is accepted, and one request is taken every cycle while the receiver does not stall.
// The single result register sets the rate: s_tready is high whenever that
// register is empty or is being drained in the same cycle.
// When the receiver stalls, the result holds and s_tready drops until it is taken.
// Thresholds are written through the APB port at byte addresses 0, 4, 8 and 12
// (debounce, hold, short minimum, short maximum), low 16 bits of pwdata.
// Reset clears the result register, restores the default thresholds and returns
// the detector to the released state with the pin assumed high.
module button_press_classifier #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: [0] pin_level, [7:1] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // m_tdata: [1:0] event_res, [2] hold_reached, [3] pressed, [7:4] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpc_pkg::*;

    localparam int WW = (COUNTER_BITS > LIMIT_BITS) ? COUNTER_BITS : LIMIT_BITS;

    logic [LIMIT_BITS-1:0]   debounce_reg, hold_reg, short_min_reg, short_max_reg;
    logic                    prev_level_reg;
    logic                    window_reg, window_next;
    logic [COUNTER_BITS-1:0] window_cnt_reg, window_cnt_next;
    logic                    pressed_reg, pressed_next;
    logic                    pending_reg, pending_next;
    logic [COUNTER_BITS-1:0] duration_reg, duration_next;
    logic                    out_valid_reg;
    bpc_result_t             result_reg, result_next;

    logic [COUNTER_BITS-1:0] cnt_max;
    logic [WW-1:0]           cnt_max_w, hold_lim, deb_lim;
    logic [COUNTER_BITS-1:0] dur_inc, win_inc;
    logic                    pin, in_fire, cfg_write, sample, edge_seen;
    bpc_reg_t                reg_sel;

    assign cnt_max   = {COUNTER_BITS{1'b1}};
    assign cnt_max_w = WW'(cnt_max);
    assign hold_lim  = (WW'(hold_reg) > cnt_max_w) ? cnt_max_w : WW'(hold_reg);
    assign deb_lim   = (WW'(debounce_reg) > cnt_max_w) ? cnt_max_w : WW'(debounce_reg);

    assign pin      = s_tdata[0];
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign reg_sel   = bpc_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_sel)
            REG_DEBOUNCE:  prdata = {16'd0, debounce_reg};
            REG_HOLD:      prdata = {16'd0, hold_reg};
            REG_SHORT_MIN: prdata = {16'd0, short_min_reg};
            REG_SHORT_MAX: prdata = {16'd0, short_max_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            hold_reg      <= HOLD_RESET;
            short_min_reg <= SHORT_MIN_RESET;
            short_max_reg <= SHORT_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_DEBOUNCE:  debounce_reg  <= pwdata[LIMIT_BITS-1:0];
                REG_HOLD:      hold_reg      <= pwdata[LIMIT_BITS-1:0];
                REG_SHORT_MIN: short_min_reg <= pwdata[LIMIT_BITS-1:0];
                REG_SHORT_MAX: short_max_reg <= pwdata[LIMIT_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign dur_inc = (duration_reg != cnt_max) ? duration_reg + 1'b1 : duration_reg;
    assign win_inc = (window_cnt_reg != cnt_max) ? window_cnt_reg + 1'b1 : window_cnt_reg;
    assign sample  = window_reg && (WW'(win_inc) >= deb_lim);
    // armed edge: falling while released, rising while pressed
    assign edge_seen = pressed_reg ? (!prev_level_reg && pin) : (prev_level_reg && !pin);

    always_comb
    begin
        window_next     = window_reg;
        window_cnt_next = window_cnt_reg;
        pressed_next    = pressed_reg;
        pending_next    = pending_reg;
        duration_next   = duration_reg;
        result_next     = '0;
        result_next.event_res = EV_NONE;

        if (pressed_reg)
        begin
            duration_next = dur_inc;
            if (!pending_reg && (WW'(dur_inc) >= hold_lim))
            begin
                pending_next             = 1'b1;
                result_next.hold_reached = 1'b1;
            end
        end

        if (window_reg)
        begin
            window_cnt_next = win_inc;
            if (sample)
            begin
                window_next = 1'b0;
                if (!pin && !pressed_reg)
                begin
                    pressed_next  = 1'b1;
                    pending_next  = 1'b0;
                    duration_next = '0;
                end
                else if (pin && pressed_reg)
                begin
                    pressed_next = 1'b0;
                    // a hold reached on this very tick still counts
                    if (pending_next)
                        result_next.event_res = EV_SHUTDOWN;
                    else if ((WW'(dur_inc) >= WW'(short_min_reg)) &&
                             (WW'(dur_inc) < WW'(short_max_reg)))
                        result_next.event_res = EV_SHORT;
                    pending_next = 1'b0;
                end
            end
        end
        else if (edge_seen)
        begin
            window_next     = 1'b1;
            window_cnt_next = '0;
        end

        result_next.pressed = pressed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            window_reg     <= 1'b0;
            window_cnt_reg <= '0;
            pressed_reg    <= 1'b0;
            pending_reg    <= 1'b0;
            duration_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                prev_level_reg <= pin;
                window_reg     <= window_next;
                window_cnt_reg <= window_cnt_next;
                pressed_reg    <= pressed_next;
                pending_reg    <= pending_next;
                duration_reg   <= duration_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload register: load on every accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_reg <= '0;
        else if (in_fire)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

endmodule

// File: design/bpc_checker.sv
// Port-level checker for the button press classifier, bound to the top level.
module bpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import bpc_pkg::*;

    // hold limit is reached while held down, or on the tick the release reports shutdown
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[3] || (m_tdata[1:0] == EV_SHUTDOWN))
        else $error("hold_reached reported while released");

    // a reported event always comes with the released state
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] != EV_NONE) |-> !m_tdata[3])
        else $error("event reported while still pressed");

    // an empty result stage must take a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
